@@ src/dsp_pkg.sv @@
`timescale 1ns / 1ps
package dsp_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic [31:0] HASH_MUL = 32'd2654435761;
  localparam logic [31:0] GATE_THRESHOLD = 32'd4290672327;
  localparam logic signed [17:0] POS_MAX = 18'sd131071;
  localparam logic signed [17:0] POS_MIN = -18'sd131072;
  localparam logic signed [31:0] Z_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Z_MIN = 32'sh80000000;
  localparam logic [16:0] ONE_Q = 17'd65536;

  typedef enum logic [2:0] {
    REG_Z_SCALE = 3'd0, REG_KEEP = 3'd1, REG_CX = 3'd2,
    REG_CY = 3'd3, REG_INV = 3'd4, REG_CHAN = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0, KIND_MIN = 2'd1, KIND_MAX = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BS_IDLE, BS_DIV, BS_EMIT
  } back_state_t;

  // One classified sample handed from front to back.
  typedef struct packed {
    logic               keep;
    logic               last;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [31:0] z;
    logic        [23:0] a;
    logic        [23:0] r;
    logic        [23:0] g;
    logic        [23:0] b;
    logic        [31:0] idx;
  } work_t;
endpackage

@@ src/dsp_front.sv @@
`timescale 1ns / 1ps
module dsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  px,
  input  logic signed [15:0]  py,
  input  logic signed [23:0]  a_in,
  input  logic signed [23:0]  r_in,
  input  logic signed [23:0]  g_in,
  input  logic signed [23:0]  b_in,
  input  logic signed [31:0]  d_in,
  input  logic                last_in,
  input  logic [22:0]         z_scale,
  input  logic [31:0]         keep_threshold,
  input  logic signed [16:0]  center_x_sum,
  input  logic signed [16:0]  center_y_sum,
  input  logic [16:0]         inv_extent,
  input  logic [3:0]          chan,
  output logic                out_valid,
  input  logic                out_ready,
  output dsp_pkg::work_t      out_data
);
  // Stage 1 registers: products; stage 2: rounding and queue entry.
  logic               s1_valid, s2_valid;
  logic signed [35:0] s1_xp, s1_yp;
  logic signed [55:0] s1_zp;
  logic [31:0]        s1_h;
  logic               s1_lowa, s1_last;
  logic signed [23:0] s1_a, s1_r, s1_g, s1_b;
  logic [31:0]        s1_idx, count;
  dsp_pkg::work_t     s2;
  logic               adv1, adv2;

  logic signed [23:0] a_sel, r_sel, g_sel, b_sel;
  logic signed [17:0] xd, yd;

  assign adv2 = !s2_valid || out_ready;
  assign adv1 = !s1_valid || adv2;
  assign in_ready = adv1;
  assign out_valid = s2_valid;
  assign out_data = s2;

  always_comb begin
    a_sel = chan[3] ? a_in : 24'sd65536;
    r_sel = chan[0] ? r_in : 24'sd32768;
    g_sel = chan[1] ? g_in : 24'sd32768;
    b_sel = chan[2] ? b_in : 24'sd32768;
    xd = 18'(signed'({px, 1'b0})) - 18'(center_x_sum);
    yd = 18'(center_y_sum) - 18'(signed'({py, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      count <= '0;
    end else if (adv1) begin
      s1_valid <= in_valid;
      if (in_valid) count <= last_in ? '0 : count + 32'd1;
    end
    if (adv1) begin
      s1_xp <= xd * $signed({1'b0, inv_extent});
      s1_yp <= yd * $signed({1'b0, inv_extent});
      s1_zp <= -(56'(d_in) * $signed({1'b0, z_scale}));
      s1_h <= 32'(count * dsp_pkg::HASH_MUL);
      s1_lowa <= (42'(a_sel) * 42'sd1000) < 42'sd65536;
      s1_last <= last_in;
      s1_a <= a_sel; s1_r <= r_sel; s1_g <= g_sel; s1_b <= b_sel;
      s1_idx <= count;
    end
  end

  function automatic logic signed [55:0] rnd(input logic signed [55:0] v,
                                             input int s);
    logic [55:0] m;
    begin
      m = v[55] ? 56'(-v) : 56'(v);
      m = (m + (56'd1 << (s - 1))) >> s;
      rnd = v[55] ? -$signed(m) : $signed(m);
    end
  endfunction

  logic signed [55:0] xr, yr, zr;
  always_comb begin
    xr = rnd(56'(s1_xp), 1);
    yr = rnd(56'(s1_yp), 1);
    zr = rnd(s1_zp, dsp_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (adv2) s2_valid <= s1_valid;
    if (adv2) begin
      s2.keep <= !s1_lowa && !(keep_threshold < dsp_pkg::GATE_THRESHOLD &&
                               s1_h > keep_threshold);
      s2.last <= s1_last;
      s2.x <= xr > 56'(dsp_pkg::POS_MAX) ? dsp_pkg::POS_MAX :
              xr < 56'(dsp_pkg::POS_MIN) ? dsp_pkg::POS_MIN : xr[17:0];
      s2.y <= yr > 56'(dsp_pkg::POS_MAX) ? dsp_pkg::POS_MAX :
              yr < 56'(dsp_pkg::POS_MIN) ? dsp_pkg::POS_MIN : yr[17:0];
      s2.z <= zr > 56'(dsp_pkg::Z_MAX) ? dsp_pkg::Z_MAX :
              zr < 56'(dsp_pkg::Z_MIN) ? dsp_pkg::Z_MIN : zr[31:0];
      s2.a <= s1_a; s2.r <= s1_r; s2.g <= s1_g; s2.b <= s1_b;
      s2.idx <= s1_idx;
    end
  end
endmodule

@@ src/dsp_queue.sv @@
`timescale 1ns / 1ps
module dsp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dsp_pkg::work_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dsp_pkg::work_t out_data
);
  dsp_pkg::work_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] fill;
  logic wr, rd;
  assign in_ready = fill != 3'd4;
  assign out_valid = fill != 3'd0;
  assign wr = in_valid && in_ready;
  assign rd = out_valid && out_ready;
  assign out_data = mem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; fill <= '0;
    end else begin
      if (wr) wp <= wp + 2'd1;
      if (rd) rp <= rp + 2'd1;
      fill <= fill + {2'b0, wr} - {2'b0, rd};
    end
    if (wr) mem[wp] <= in_data;
  end
endmodule

@@ src/dsp_back.sv @@
`timescale 1ns / 1ps
module dsp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsp_pkg::work_t      in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic signed [17:0]  pos_x,
  output logic signed [17:0]  pos_y,
  output logic signed [31:0]  pos_z,
  output logic [16:0]         red_out,
  output logic [16:0]         green_out,
  output logic [16:0]         blue_out,
  output logic [31:0]         source_index,
  output logic                run_last
);
  dsp_pkg::back_state_t state, state_next;
  dsp_pkg::work_t w;
  logic [1:0] phase;
  logic [5:0] step;
  // Three restoring dividers in lockstep: (2c*2^16 + a) / (2a).
  logic [41:0] rem [3];
  logic [41:0] num [3];
  logic [41:0] quo [3];
  logic [41:0] den;
  logic signed [17:0] mnx, mny, mxx, mxy;
  logic signed [31:0] mnz, mxz;
  logic take, fire;

  assign in_ready = state == dsp_pkg::BS_IDLE;
  assign take = in_valid && in_ready;
  assign fire = out_valid && out_ready;

  // A dropped sample that does not end the frame yields nothing: stay idle.
  always_comb begin
    state_next = state;
    case (state)
      dsp_pkg::BS_IDLE:
        if (take) begin
          if (in_data.keep) state_next = dsp_pkg::BS_DIV;
          else if (in_data.last) state_next = dsp_pkg::BS_EMIT;
          else state_next = dsp_pkg::BS_IDLE;
        end
      dsp_pkg::BS_DIV: if (step == 6'd0) state_next = dsp_pkg::BS_EMIT;
      dsp_pkg::BS_EMIT:
        if (fire && run_last) state_next = dsp_pkg::BS_IDLE;
      default: state_next = dsp_pkg::BS_IDLE;
    endcase
  end

  function automatic logic [16:0] clampq(input logic [41:0] q,
                                         input logic signed [23:0] c);
    begin
      if (c <= 0) clampq = '0;
      else if (q > 42'(dsp_pkg::ONE_Q)) clampq = dsp_pkg::ONE_Q;
      else clampq = q[16:0];
    end
  endfunction

  always_comb begin
    out_valid = state == dsp_pkg::BS_EMIT;
    kind = dsp_pkg::KIND_POINT;
    pos_x = w.x; pos_y = w.y; pos_z = w.z;
    red_out = '0; green_out = '0; blue_out = '0;
    source_index = '0;
    run_last = 1'b0;
    case (phase)
      2'd0: begin
        red_out = clampq(quo[0], w.r);
        green_out = clampq(quo[1], w.g);
        blue_out = clampq(quo[2], w.b);
        source_index = w.idx;
        run_last = !w.last;
      end
      2'd1: begin
        kind = dsp_pkg::KIND_MIN;
        pos_x = mnx; pos_y = mny; pos_z = mnz;
      end
      default: begin
        kind = dsp_pkg::KIND_MAX;
        pos_x = mxx; pos_y = mxy; pos_z = mxz;
        run_last = 1'b1;
      end
    endcase
  end

  logic [42:0] trial [3];
  logic [41:0] rsh [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsh[i] = {rem[i][40:0], num[i][41]};
      trial[i] = {1'b0, rsh[i]} - {1'b0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsp_pkg::BS_IDLE;
      mnx <= dsp_pkg::POS_MAX; mny <= dsp_pkg::POS_MAX; mnz <= dsp_pkg::Z_MAX;
      mxx <= dsp_pkg::POS_MIN; mxy <= dsp_pkg::POS_MIN; mxz <= dsp_pkg::Z_MIN;
    end else begin
      state <= state_next;
      if (take && in_data.keep) begin
        if (in_data.x < mnx) mnx <= in_data.x;
        if (in_data.y < mny) mny <= in_data.y;
        if (in_data.z < mnz) mnz <= in_data.z;
        if (in_data.x > mxx) mxx <= in_data.x;
        if (in_data.y > mxy) mxy <= in_data.y;
        if (in_data.z > mxz) mxz <= in_data.z;
      end
      if (fire && phase == 2'd2) begin
        mnx <= dsp_pkg::POS_MAX; mny <= dsp_pkg::POS_MAX; mnz <= dsp_pkg::Z_MAX;
        mxx <= dsp_pkg::POS_MIN; mxy <= dsp_pkg::POS_MIN; mxz <= dsp_pkg::Z_MIN;
      end
    end
    if (take) begin
      w <= in_data;
      phase <= in_data.keep ? 2'd0 : 2'd1;
      step <= 6'd41;
      den <= {17'd0, in_data.a, 1'b0};
      num[0] <= ({18'd0, in_data.r} << 17) + {18'd0, in_data.a};
      num[1] <= ({18'd0, in_data.g} << 17) + {18'd0, in_data.a};
      num[2] <= ({18'd0, in_data.b} << 17) + {18'd0, in_data.a};
      for (int i = 0; i < 3; i++) begin
        rem[i] <= '0; quo[i] <= '0;
      end
    end else if (state == dsp_pkg::BS_DIV) begin
      step <= step - 6'd1;
      for (int i = 0; i < 3; i++) begin
        num[i] <= num[i] << 1;
        if (!trial[i][42]) begin
          rem[i] <= trial[i][41:0];
          quo[i] <= {quo[i][40:0], 1'b1};
        end else begin
          rem[i] <= rsh[i];
          quo[i] <= {quo[i][40:0], 1'b0};
        end
      end
    end else if (fire && !run_last) begin
      phase <= phase + 2'd1;
    end
  end
endmodule

@@ src/deep_sample_to_point_converter.sv @@
`timescale 1ns / 1ps
// Deep-sample to point converter. Each sample item on s_axis takes a running
// index; samples with alpha under 0.001, or thinned by the index hash against
// keep_threshold, are dropped. A kept sample yields a point (kind 0) with
// centered, scaled x/y, negated scaled z and unpremultiplied colour. After a
// sample with frame_last the bounding box min and max corners follow and the
// box and index restart. The front pipeline (2 stages) classifies at one item
// per cycle, when the 4-entry queue it feeds has room; the back unit handles
// one item at a time: it loads each item, runs a kept sample through the
// bit-serial colour divider, and then emits each result. A dropped sample
// yields no result unless it ends the frame. Sustained throughput of kept
// samples is thus set by the serial divider.
module deep_sample_to_point_converter (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pixel_x[15:0], pixel_y[31:16], alpha_in[55:32], red_in[79:56],
  // green_in[103:80], blue_in[127:104], depth_in[159:128]
  input  logic [159:0] s_axis_tdata,
  input  logic         s_axis_tlast,   // frame_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[17:0], pos_y[35:18], pos_z[67:36], red_out[84:68],
  // green_out[101:85], blue_out[118:102], source_index[150:119], zeros
  output logic [151:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // kind
  output logic         m_axis_tlast    // run_last
);
  logic [22:0] z_scale;
  logic [31:0] keep_threshold;
  logic signed [16:0] center_x_sum, center_y_sum;
  logic [16:0] inv_extent;
  logic [3:0] chan;

  assign cfg_ready = 1'b1;

  // Hold register values; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      z_scale <= 23'd65536;
      keep_threshold <= '1;
      center_x_sum <= '0;
      center_y_sum <= '0;
      inv_extent <= 17'd65536;
      chan <= 4'hF;
    end else if (cfg_valid) begin
      case (cfg_index)
        dsp_pkg::REG_Z_SCALE: z_scale <= cfg_data[22:0];
        dsp_pkg::REG_KEEP:    keep_threshold <= cfg_data;
        dsp_pkg::REG_CX:      center_x_sum <= cfg_data[16:0];
        dsp_pkg::REG_CY:      center_y_sum <= cfg_data[16:0];
        dsp_pkg::REG_INV:     inv_extent <= cfg_data[16:0];
        dsp_pkg::REG_CHAN:    chan <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  dsp_pkg::work_t f_data, q_data;
  logic f_valid, f_ready, q_valid, q_ready;
  logic signed [17:0] px, py;
  logic signed [31:0] pz;
  logic [16:0] ro, go, bo;
  logic [31:0] si;

  dsp_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .px(s_axis_tdata[15:0]), .py(s_axis_tdata[31:16]),
    .a_in(s_axis_tdata[55:32]), .r_in(s_axis_tdata[79:56]),
    .g_in(s_axis_tdata[103:80]), .b_in(s_axis_tdata[127:104]),
    .d_in(s_axis_tdata[159:128]), .last_in(s_axis_tlast),
    .z_scale, .keep_threshold, .center_x_sum, .center_y_sum,
    .inv_extent, .chan,
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  dsp_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  dsp_back u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .kind(m_axis_tuser), .pos_x(px), .pos_y(py), .pos_z(pz),
    .red_out(ro), .green_out(go), .blue_out(bo),
    .source_index(si), .run_last(m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, si, bo, go, ro, pz, py, px};
endmodule
